[hdl/itsel_pkg.sv]
// ============================================================================
// itsel_pkg
// Shared types and constants of the iterative threshold selector.
// ============================================================================
package itsel_pkg;

    localparam int unsigned SampleW  = 16;
    localparam int unsigned IterW    = 8;
    localparam int unsigned StepW    = 16;
    localparam int unsigned StatusW  = 2;

    typedef enum logic [StatusW-1:0] {
        ST_CONVERGED = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_EMPTY     = 2'd2
    } t_status;

    localparam logic [0:0] REG_MIN_STEP = 1'b0;
    localparam logic [0:0] REG_MAX_ITER = 1'b1;

    typedef struct packed {
        logic signed [SampleW-1:0] pixel;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic signed [SampleW-1:0] threshold;
        logic [IterW-1:0]          iterations;
        logic [StatusW-1:0]        status;
    } t_out_item;

endpackage

[hdl/isodata_threshold_select.sv]
// ============================================================================
// isodata_threshold_select
// Iterative (ISODATA) threshold selection over one stored frame.
// ============================================================================
// Input channel: one pixel item per handshake, last marks the frame end.
// Pixels load one per cycle into a frame memory while the sum accumulates.
// On the last item the block stops taking items, derives the frame mean with
// a shared restoring divider (one quotient bit per cycle), then repeats passes
// over the memory: one pixel per cycle, then two class divisions and a
// midpoint; a pass with an empty class ends the frame instead. The sum
// width SUMW is 27 by default; the block has a single divider and a
// single memory read port.
// Output channel: one result item per frame, held in an output register
// until taken; the next frame loads while it waits, and the block finishes
// the following frame only once that register is free.
// Configuration: APB writes to min_step (0x0) and max_iterations (0x4).
// Reset (synchronous, active low) clears counters, sequencer, output register,
// loads min_step 1, max_iterations 32; the frame memory needs no clearing.
// ============================================================================
module isodata_threshold_select #(
    parameter int unsigned MAX_PIXELS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  itsel_pkg::t_in_item    i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output itsel_pkg::t_out_item   o_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int unsigned SW     = itsel_pkg::SampleW;
    localparam int unsigned AW     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int unsigned CW     = $clog2(MAX_PIXELS + 1);
    localparam int unsigned SUMW   = SW + CW;
    localparam int unsigned QCW    = $clog2(SUMW + 1);

    typedef enum logic [9:0] {
        S_LOAD  = 10'b0000000001,
        S_MEAN  = 10'b0000000010,
        S_MWAIT = 10'b0000000100,
        S_PASS  = 10'b0000001000,
        S_PTAIL = 10'b0000010000,
        S_CHECK = 10'b0000100000,
        S_LDIV  = 10'b0001000000,
        S_HDIV  = 10'b0010000000,
        S_NEXT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [itsel_pkg::StepW-1:0] r_min_step;
    logic [itsel_pkg::IterW-1:0] r_max_iter;

    logic signed [SW-1:0] r_mem [MAX_PIXELS];
    logic signed [SW-1:0] r_rd;

    logic [CW-1:0]          r_cnt;
    logic signed [SUMW-1:0] r_sum;
    logic [CW-1:0]          r_idx;
    logic                   r_rd_v;
    logic signed [SW-1:0]   r_thr;
    logic signed [SUMW-1:0] r_lsum, r_hsum;
    logic [CW-1:0]          r_lcnt;
    logic [itsel_pkg::IterW-1:0] r_pass;
    logic signed [SW-1:0]   r_lmean;
    logic                   r_stop;

    // shared divider: floor(num / den), den > 0
    logic [SUMW-1:0]  r_dnum;
    logic [SUMW:0]    r_drem;
    logic [CW-1:0]    r_dden;
    logic             r_dneg;
    logic [QCW-1:0]   r_dstep;
    logic             r_dbusy;
    logic             div_start, div_done;
    logic signed [SUMW-1:0] div_num;
    logic [CW-1:0]    div_den;
    logic signed [SUMW:0] div_q;
    logic [SUMW:0]    trial;

    logic              r_ovalid;
    itsel_pkg::t_out_item r_odata;

    assign pready = 1'b1;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_ready = (r_state == S_LOAD);

    always_comb begin
        prdata = '0;
        case (paddr[2])
            itsel_pkg::REG_MIN_STEP: prdata = 32'(r_min_step);
            itsel_pkg::REG_MAX_ITER: prdata = 32'(r_max_iter);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step <= 16'd1;
            r_max_iter <= 8'd32;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                itsel_pkg::REG_MIN_STEP: r_min_step <= pwdata[15:0];
                itsel_pkg::REG_MAX_ITER: r_max_iter <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    logic in_acc, store;
    assign in_acc = i_valid && o_ready;
    assign store  = in_acc && (r_cnt < CW'(MAX_PIXELS));

    always_ff @(posedge i_clk) begin
        if (store) r_mem[r_cnt[AW-1:0]] <= i_data.pixel;
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // divider datapath
    assign trial = {r_drem[SUMW-1:0], r_dnum[SUMW-1]} - {{(SUMW+1-CW){1'b0}}, r_dden};
    assign div_done = r_dbusy && (r_dstep == '0);
    always_comb begin
        logic [SUMW:0] qm;
        qm = {1'b0, r_dnum};
        if (r_dneg) div_q = (r_drem != '0) ? -$signed(qm) - 1 : -$signed(qm);
        else        div_q = $signed(qm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dstep <= '0;
        end else if (div_start) begin
            r_dbusy <= 1'b1;
            r_dstep <= QCW'(SUMW);
            r_dneg  <= div_num[SUMW-1];
            r_dnum  <= div_num[SUMW-1] ? SUMW'(-div_num) : SUMW'(div_num);
            r_dden  <= div_den;
            r_drem  <= '0;
        end else if (r_dbusy) begin
            if (r_dstep == '0) begin
                r_dbusy <= 1'b0;
            end else begin
                r_dstep <= r_dstep - 1'b1;
                if (!trial[SUMW]) begin
                    r_drem <= trial;
                    r_dnum <= {r_dnum[SUMW-2:0], 1'b1};
                end else begin
                    r_drem <= {r_drem[SUMW-1:0], r_dnum[SUMW-1]};
                    r_dnum <= {r_dnum[SUMW-2:0], 1'b0};
                end
            end
        end
    end

    logic [CW-1:0] hcnt;
    assign hcnt = r_cnt - r_lcnt;

    logic signed [SW:0]   mid;
    logic signed [SW-1:0] nthr;
    logic [SW:0]          diff;
    logic [itsel_pkg::IterW-1:0] limit;
    assign mid   = (SW+1)'(r_lmean) + (SW+1)'($signed(div_q[SW-1:0]));
    assign nthr  = SW'(mid >>> 1);
    assign diff  = (nthr >= r_thr) ? (SW+1)'(nthr) - (SW+1)'(r_thr)
                                   : (SW+1)'(r_thr) - (SW+1)'(nthr);
    assign limit = (r_max_iter == '0) ? 8'd1 : r_max_iter;

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = r_sum;
        div_den   = r_cnt;
        case (r_state)
            S_LOAD:  if (in_acc && i_data.last) n_state = S_MEAN;
            S_MEAN:  if (!r_ovalid) begin
                div_start = 1'b1;
                n_state   = S_MWAIT;
            end
            S_MWAIT: if (div_done) n_state = S_PASS;
            S_PASS:  if (r_idx == r_cnt) n_state = S_PTAIL;
            S_PTAIL: n_state = S_CHECK;
            S_CHECK: begin
                if (r_lcnt == '0 || hcnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    div_num   = r_lsum;
                    div_den   = r_lcnt;
                    n_state   = S_LDIV;
                end
            end
            S_LDIV:  if (div_done) begin
                div_start = 1'b1;
                div_num   = r_hsum;
                div_den   = hcnt;
                n_state   = S_HDIV;
            end
            S_HDIV:  if (div_done) n_state = S_NEXT;
            S_NEXT:  n_state = r_stop ? S_OUT : S_PASS;
            S_OUT:   n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_idx    <= '0;
            r_rd_v   <= 1'b0;
            r_thr    <= '0;
            r_lsum   <= '0;
            r_hsum   <= '0;
            r_lcnt   <= '0;
            r_pass   <= '0;
            r_lmean  <= '0;
            r_ovalid <= 1'b0;
            r_odata  <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            r_rd_v <= (r_state == S_PASS) && (r_idx != r_cnt);
            if (r_rd_v) begin
                if (r_rd <= r_thr) begin
                    r_lsum <= r_lsum + SUMW'(r_rd);
                    r_lcnt <= r_lcnt + 1'b1;
                end else begin
                    r_hsum <= r_hsum + SUMW'(r_rd);
                end
            end
            case (r_state)
                S_LOAD: if (store) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sum <= r_sum + SUMW'(i_data.pixel);
                end
                S_MEAN: begin
                    r_pass <= '0;
                end
                S_MWAIT: if (div_done) begin
                    r_thr  <= SW'(div_q);
                    r_idx  <= '0;
                    r_lsum <= '0;
                    r_hsum <= '0;
                    r_lcnt <= '0;
                end
                S_PASS: if (r_idx != r_cnt) r_idx <= r_idx + 1'b1;
                S_CHECK: if (r_lcnt == '0 || hcnt == '0) begin
                    r_odata.status <= itsel_pkg::ST_EMPTY;
                end
                S_LDIV: if (div_done) r_lmean <= SW'(div_q);
                S_HDIV: if (div_done) begin
                    r_thr  <= nthr;
                    r_pass <= r_pass + 1'b1;
                    r_idx  <= '0;
                    r_lsum <= '0;
                    r_hsum <= '0;
                    r_lcnt <= '0;
                    if (diff <= (SW+1)'(r_min_step)) begin
                        r_odata.status <= itsel_pkg::ST_CONVERGED;
                    end else if (r_pass + 1'b1 >= limit) begin
                        r_odata.status <= itsel_pkg::ST_LIMIT;
                    end
                end
                S_OUT: begin
                    r_odata.threshold  <= r_thr;
                    r_odata.iterations <= r_pass;
                    r_ovalid <= 1'b1;
                    r_cnt    <= '0;
                    r_sum    <= '0;
                end
                default: ;
            endcase
        end
    end

    // hold the stop decision of the pass for NEXT
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_stop <= 1'b0;
        else if (r_state == S_HDIV && div_done)
            r_stop <= (diff <= (SW+1)'(r_min_step)) || (r_pass + 1'b1 >= limit);
    end

endmodule
